FILE: design/bpf_pkg.sv
// shared types, constants and crc helper for the program packet framer
`default_nettype none

package bpf_pkg;

    localparam int BPF_QUEUE_DEPTH = 4;

    localparam logic [7:0]  PKT_HEADER      = 8'h80;
    localparam logic [7:0]  PKT_CMD_PROGRAM = 8'h20;
    localparam logic [7:0]  PKT_LEN_EXTRA   = 8'd5;
    localparam logic [7:0]  PKT_ZERO        = 8'h00;
    localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
    localparam logic [7:0]  CHUNK_RESET     = 8'd128;
    localparam logic [7:0]  CHUNK_MAX       = 8'd250;

    // register indexes on the config port
    localparam logic REG_MAX_CHUNK = 1'b0;

    // header byte positions
    localparam logic [2:0] HDR_LEN  = 3'd1;
    localparam logic [2:0] HDR_ZERO = 3'd2;
    localparam logic [2:0] HDR_CMD  = 3'd3;
    localparam logic [2:0] HDR_LAST = 3'd7;
    localparam logic [1:0] CRC_LAST = 2'd3;

    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;
        logic        last;
        logic [7:0]  len;
        logic [31:0] addr;
    } bpf_job_t;

    typedef enum logic [1:0] {
        ST_JOB,
        ST_HEAD,
        ST_DATA,
        ST_CRC
    } bpf_state_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/bpf_front.sv
// front end: tracks segment and chunk position and classifies each byte into a job
`default_nettype none

module bpf_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire logic [7:0]      data_byte,
    input  wire logic            segment_start,
    input  wire logic [31:0]     segment_address,
    input  wire logic [23:0]     segment_length,
    input  wire logic [7:0]      max_chunk,
    output      logic            push,
    output      bpf_pkg::bpf_job_t job
);
    import bpf_pkg::*;

    logic [23:0] segment_left_reg, segment_left_next;
    logic [7:0]  chunk_left_reg, chunk_left_next;
    logic [31:0] next_address_reg, next_address_next;

    logic [23:0] seg_eff;
    logic [7:0]  chunk_eff;
    logic [31:0] addr_eff;
    logic [7:0]  lim;
    logic [7:0]  len;
    logic [7:0]  clen;
    logic        accept;
    logic        hdr;

    assign accept    = in_valid && in_ready;
    assign seg_eff   = segment_start ? segment_length : segment_left_reg;
    assign chunk_eff = segment_start ? 8'd0 : chunk_left_reg;
    assign addr_eff  = segment_start ? segment_address : next_address_reg;

    always_comb
    begin
        lim = max_chunk;
        if (lim == 8'd0)
        begin
            lim = 8'd1;
        end
        if (lim > CHUNK_MAX)
        begin
            lim = CHUNK_MAX;
        end
    end

    assign len  = (seg_eff < {16'd0, lim}) ? seg_eff[7:0] : lim;
    assign hdr  = (chunk_eff == 8'd0);
    assign clen = hdr ? len : chunk_eff;

    assign push      = accept && (seg_eff != 24'd0);
    assign job.data  = data_byte;
    assign job.hdr   = hdr;
    assign job.last  = (clen == 8'd1);
    assign job.len   = len;
    assign job.addr  = addr_eff;

    always_comb
    begin
        segment_left_next = segment_left_reg;
        chunk_left_next   = chunk_left_reg;
        next_address_next = next_address_reg;
        if (accept)
        begin
            segment_left_next = seg_eff;
            chunk_left_next   = chunk_eff;
            next_address_next = addr_eff;
            if (seg_eff != 24'd0)
            begin
                segment_left_next = seg_eff - 24'd1;
                chunk_left_next   = clen - 8'd1;
                if (hdr)
                begin
                    next_address_next = addr_eff + {24'd0, len};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_left_reg <= '0;
            chunk_left_reg   <= '0;
            next_address_reg <= '0;
        end
        else
        begin
            segment_left_reg <= segment_left_next;
            chunk_left_reg   <= chunk_left_next;
            next_address_reg <= next_address_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/bpf_queue.sv
// short job queue between front and back
`default_nettype none

module bpf_queue #(
    parameter int DEPTH = bpf_pkg::BPF_QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bpf_pkg::bpf_job_t push_job,
    input  wire logic              pop,
    output      logic              full,
    output      logic              head_valid,
    output      bpf_pkg::bpf_job_t head_job
);
    import bpf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bpf_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/bpf_back.sv
// back end: turns jobs into header, data and crc bytes, one byte per cycle while out_ready is high and jobs are queued
`default_nettype none

module bpf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire bpf_pkg::bpf_job_t q_job,
    output      logic              pop,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [7:0]        out_byte,
    output      logic              packet_end
);
    import bpf_pkg::*;

    bpf_state_t  st_reg, st_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] crc_reg, crc_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg;
    logic        m_last_reg;

    logic        adv;
    logic        emit;
    logic [7:0]  byte_sel;
    logic        end_sel;
    logic [7:0]  hb;

    assign adv        = !m_valid_reg || out_ready;
    assign out_valid  = m_valid_reg;
    assign out_byte   = m_data_reg;
    assign packet_end = m_last_reg;

    always_comb
    begin
        case (idx_reg)
            HDR_LEN:  hb = q_job.len + PKT_LEN_EXTRA;
            HDR_ZERO: hb = PKT_ZERO;
            HDR_CMD:  hb = PKT_CMD_PROGRAM;
            default:  hb = q_job.addr[{idx_reg[1:0], 3'b000} +: 8];
        endcase
    end

    // next state
    always_comb
    begin
        st_next  = st_reg;
        idx_next = idx_reg;
        case (st_reg)
            ST_JOB:
            begin
                if (q_valid && adv)
                begin
                    if (q_job.hdr)
                    begin
                        st_next  = ST_HEAD;
                        idx_next = HDR_LEN;
                    end
                    else if (q_job.last)
                    begin
                        st_next  = ST_CRC;
                        idx_next = '0;
                    end
                end
            end
            ST_HEAD:
            begin
                if (adv)
                begin
                    if (idx_reg == HDR_LAST)
                    begin
                        st_next = ST_DATA;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_DATA:
            begin
                if (adv)
                begin
                    idx_next = '0;
                    st_next  = q_job.last ? ST_CRC : ST_JOB;
                end
            end
            ST_CRC:
            begin
                if (adv)
                begin
                    if (idx_reg[1:0] == CRC_LAST)
                    begin
                        st_next  = ST_JOB;
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                st_next  = ST_JOB;
                idx_next = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        emit     = 1'b0;
        byte_sel = PKT_ZERO;
        end_sel  = 1'b0;
        pop      = 1'b0;
        crc_next = crc_reg;
        case (st_reg)
            ST_JOB:
            begin
                if (q_valid && adv)
                begin
                    emit = 1'b1;
                    if (q_job.hdr)
                    begin
                        byte_sel = PKT_HEADER;
                    end
                    else
                    begin
                        byte_sel = q_job.data;
                        crc_next = crc_byte(crc_reg, q_job.data);
                        pop      = 1'b1;
                    end
                end
            end
            ST_HEAD:
            begin
                if (adv)
                begin
                    emit     = 1'b1;
                    byte_sel = hb;
                    if (idx_reg == HDR_CMD)
                    begin
                        crc_next = crc_byte(CRC_INIT, hb);
                    end
                    else if (idx_reg > HDR_CMD)
                    begin
                        crc_next = crc_byte(crc_reg, hb);
                    end
                end
            end
            ST_DATA:
            begin
                if (adv)
                begin
                    emit     = 1'b1;
                    byte_sel = q_job.data;
                    crc_next = crc_byte(crc_reg, q_job.data);
                    pop      = 1'b1;
                end
            end
            ST_CRC:
            begin
                if (adv)
                begin
                    emit     = 1'b1;
                    byte_sel = crc_reg[{idx_reg[1:0], 3'b000} +: 8];
                    end_sel  = (idx_reg[1:0] == CRC_LAST);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign m_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_data_reg <= byte_sel;
            m_last_reg <= end_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_JOB;
            idx_reg     <= '0;
            crc_reg     <= CRC_INIT;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/bootloader_program_packet_framer_core.sv
// top level of the bootloader program packet framer
//
// s_* stream: one segment byte per transaction; s_tuser marks the first byte
// of a segment, which also carries the segment address and length.
// m_* stream: framed packet bytes, 0x80, len+5, 0x00, 0x20, address (le),
// data, crc32 with no final xor (le); m_tlast is high on each last crc byte.
// apb port: register max_chunk at address 0, written on psel & penable &
// pwrite; pready is tied high. write it only while the block is idle.
// flow: the first output byte of an input passes the job queue and the
// output register before m_tvalid rises. the output sequencer sends one byte
// per cycle while m_tready is high and jobs are queued: a data byte per input,
// plus 8 header bytes and 4 crc bytes per chunk; the output register sets
// that rate. a 4-entry job queue parts the input side from the sequencer so
// the input keeps flowing during headers. reset clears position and address
// state, sets the crc to all ones and max_chunk to 128. when m_tready is low
// the output byte holds, the queue fills and s_tready drops once it is full.
`default_nettype none

module bootloader_program_packet_framer_core #(
    parameter int QUEUE_DEPTH = bpf_pkg::BPF_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [63:0] s_tdata,   // data_byte, segment_address, segment_length
    input  wire logic        s_tuser,   // segment_start
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // out_byte
    output      logic        m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    import bpf_pkg::*;

    logic [7:0] max_chunk_reg, max_chunk_next;
    logic       cfg_wr;
    logic       full;
    logic       push;
    bpf_job_t   push_job;
    logic       q_valid;
    bpf_job_t   q_job;
    logic       pop;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_MAX_CHUNK) ? {24'd0, max_chunk_reg} : 32'd0;
    assign s_tready = !full;

    assign max_chunk_next = (cfg_wr && paddr[2] == REG_MAX_CHUNK) ? pwdata[7:0]
                                                                   : max_chunk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chunk_reg <= CHUNK_RESET;
        end
        else
        begin
            max_chunk_reg <= max_chunk_next;
        end
    end

    bpf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .data_byte       (s_tdata[7:0]),
        .segment_start   (s_tuser),
        .segment_address (s_tdata[39:8]),
        .segment_length  (s_tdata[63:40]),
        .max_chunk       (max_chunk_reg),
        .push            (push),
        .job             (push_job)
    );

    bpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (q_valid),
        .head_job   (q_job)
    );

    bpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .packet_end (m_tlast)
    );

endmodule

`default_nettype wire

FILE: design/bpf_checker.sv
// port-level checks for the program packet framer, bound to the top level
`default_nettype none

module bpf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       pready
);

    // a stalled transaction stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // nothing offered right out of reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> pready)
        else $error("pready low");

endmodule

bind bootloader_program_packet_framer_core bpf_checker u_bpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

`default_nettype wire
